// ===== rtl/packed_utf16_to_utf8_encoder_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packed UTF-16 to UTF-8 encoder
// Concurrent checks that compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef PACKED_UTF16_TO_UTF8_ENCODER_MACROS_SVH
`define PACKED_UTF16_TO_UTF8_ENCODER_MACROS_SVH

`ifndef SYNTHESIS
`define P2U8_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define P2U8_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define P2U8_ASSERT(label, clk, rst_n, prop, msg)
`define P2U8_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/p2u8_pkg.sv =====
// ----------------------------------------------------------------------------
// p2u8_pkg
// Shared types, constants and byte formatting for the UTF-8 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package p2u8_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [20:0] SuppBase  = 21'h10000;
  localparam logic [7:0]  LeadTwo   = 8'hC0;
  localparam logic [7:0]  LeadThree = 8'hE0;
  localparam logic [7:0]  LeadFour  = 8'hF0;
  localparam logic [7:0]  ContByte  = 8'h80;

  // Byte count minus one.
  typedef enum logic [1:0] {
    LEN_ONE   = 2'd0,
    LEN_TWO   = 2'd1,
    LEN_THREE = 2'd2,
    LEN_FOUR  = 2'd3
  } len_e;

  typedef struct packed {
    logic [20:0] cp;
    len_e        len;
    logic        text_end;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // Byte idx (0 = leading byte) of the encoding of e.
  function automatic logic [7:0] utf8_byte(entry_t e, logic [1:0] idx);
    logic [1:0] rem;
    logic [7:0] b;
    rem = 2'(e.len) - idx;
    b   = '0;
    case (rem)
      2'd3: b = LeadFour | {5'b0, e.cp[20:18]};
      2'd2: begin
        if (e.len == LEN_FOUR) b = ContByte | {2'b0, e.cp[17:12]};
        else                   b = LeadThree | {4'b0, e.cp[15:12]};
      end
      2'd1: begin
        if (e.len == LEN_TWO) b = LeadTwo | {3'b0, e.cp[10:6]};
        else                  b = ContByte | {2'b0, e.cp[11:6]};
      end
      default: begin
        if (e.len == LEN_ONE) b = {1'b0, e.cp[6:0]};
        else                  b = ContByte | {2'b0, e.cp[5:0]};
      end
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/p2u8_front.sv =====
// ----------------------------------------------------------------------------
// p2u8_front
// Accepts code words, forms the code point and the byte count.
// ----------------------------------------------------------------------------
`default_nettype none

module p2u8_front (
  input  logic                push_i,
  input  logic [31:0]         code_word_i,
  input  logic                text_end_i,
  input  logic                q_full_i,
  output logic                q_wr_o,
  output p2u8_pkg::entry_t    q_entry_o
);
  import p2u8_pkg::*;

  logic [9:0] hi_payload;
  logic [9:0] lo_payload;

  assign hi_payload = code_word_i[25:16];
  assign lo_payload = code_word_i[9:0];

  assign q_wr_o = push_i && !q_full_i;

  always_comb begin
    q_entry_o.text_end = text_end_i;
    if (code_word_i[31:16] != 16'h0) begin
      // Surrogate pair: tag bits ignored.
      q_entry_o.cp  = SuppBase + {1'b0, hi_payload, lo_payload};
      q_entry_o.len = LEN_FOUR;
    end else begin
      q_entry_o.cp = {5'b0, code_word_i[15:0]};
      if (code_word_i[15:11] != 5'h0)     q_entry_o.len = LEN_THREE;
      else if (code_word_i[10:7] != 4'h0) q_entry_o.len = LEN_TWO;
      else                                q_entry_o.len = LEN_ONE;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/p2u8_queue.sv =====
// ----------------------------------------------------------------------------
// p2u8_queue
// Small FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "packed_utf16_to_utf8_encoder_macros.svh"

module p2u8_queue #(
  parameter int unsigned DEPTH = p2u8_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  p2u8_pkg::entry_t    wr_entry_i,
  input  logic                rd_i,
  output p2u8_pkg::entry_t    rd_entry_o,
  output p2u8_pkg::q_status_t status_o
);
  import p2u8_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t            mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_wr, do_rd;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CntW'(DEPTH));
  assign do_wr = wr_i && !status_o.full;
  assign do_rd = rd_i && !status_o.empty;
  assign rd_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd)      count_d = count_q + 1'b1;
    else if (!do_wr && do_rd) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

  `P2U8_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CntW'(DEPTH), "queue overfilled")
  `P2U8_ASSERT(a_count_up, clk_i, rst_ni,
               do_wr && !do_rd |=> count_q == $past(count_q) + 1'b1,
               "queue count did not advance")
  `P2U8_ASSERT(a_count_down, clk_i, rst_ni,
               !do_wr && do_rd |=> count_q == $past(count_q) - 1'b1,
               "queue count did not drop")

endmodule

`default_nettype wire

// ===== rtl/p2u8_back.sv =====
// ----------------------------------------------------------------------------
// p2u8_back
// Walks each queued word byte by byte into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "packed_utf16_to_utf8_encoder_macros.svh"

module p2u8_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  p2u8_pkg::entry_t    q_entry_i,
  input  logic                q_empty_i,
  output logic                q_rd_o,
  input  logic                pop_i,
  output logic                empty_o,
  output logic [7:0]          utf8_byte_o,
  output logic                item_last_o,
  output logic                text_last_o
);
  import p2u8_pkg::*;

  logic       out_valid_q;
  logic [7:0] byte_q;
  logic       item_last_q, text_last_q;
  logic [1:0] idx_q, idx_d;
  logic       load, take, is_last;

  // Output register is free when empty or being taken this cycle.
  assign load    = !out_valid_q || pop_i;
  assign take    = load && !q_empty_i;
  assign is_last = (idx_q == 2'(q_entry_i.len));
  assign q_rd_o  = take && is_last;
  assign idx_d   = is_last ? 2'd0 : idx_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      if (load) out_valid_q <= !q_empty_i;
      if (take) idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q      <= utf8_byte(q_entry_i, idx_q);
      item_last_q <= is_last;
      text_last_q <= is_last && q_entry_i.text_end;
    end
  end

  assign empty_o     = !out_valid_q;
  assign utf8_byte_o = byte_q;
  assign item_last_o = item_last_q;
  assign text_last_o = text_last_q;

  `P2U8_ASSERT(a_mid_word_queued, clk_i, rst_ni,
               idx_q != 2'd0 |-> !q_empty_i,
               "byte walk without queued word")
  `P2U8_ASSERT(a_text_on_item_end, clk_i, rst_ni,
               out_valid_q && text_last_q |-> item_last_q,
               "text end off word end")
  `P2U8_ASSERT_NEVER(a_rd_from_empty, clk_i, rst_ni, q_rd_o && q_empty_i, "read from empty queue")

endmodule

`default_nettype wire

// ===== rtl/packed_utf16_to_utf8_encoder.sv =====
// ----------------------------------------------------------------------------
// packed_utf16_to_utf8_encoder
// Converts 32-bit packed UTF-16 code words into a stream of UTF-8 bytes.
// ----------------------------------------------------------------------------
//  Channel  | Handshake       | Payload
//  ---------+-----------------+----------------------------------------
//  input    | push / full     | code_word_i[31:0], text_end_i
//  output   | pop / empty     | utf8_byte_o[7:0], item_last_o, text_last_o
//
//  A word is accepted into a queue of DEPTH entries; full rises
//  only when the queue holds DEPTH words.
//  The output side drains one byte per cycle while pop is held; a word gives
//  1 to 4 bytes there; the single byte-walk unit sets the sustained rate.
//  With the queue empty and the output free, a word is written into the queue
//  and its first byte is then registered in the output register.
//  A withheld pop stalls only the output register; the queue keeps taking words until full.
//  Reset clears the queue and the output valid flag at once.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_utf16_to_utf8_encoder #(
  parameter int unsigned DEPTH = p2u8_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] code_word_i,
  input  logic        text_end_i,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  utf8_byte_o,
  output logic        item_last_o,
  output logic        text_last_o
);
  import p2u8_pkg::*;

  entry_t    wr_entry, rd_entry;
  q_status_t q_status;
  logic      q_wr, q_rd;

  assign full = q_status.full;

  p2u8_front u_front (
    .push_i      (push),
    .code_word_i (code_word_i),
    .text_end_i  (text_end_i),
    .q_full_i    (q_status.full),
    .q_wr_o      (q_wr),
    .q_entry_o   (wr_entry)
  );

  p2u8_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (q_wr),
    .wr_entry_i (wr_entry),
    .rd_i       (q_rd),
    .rd_entry_o (rd_entry),
    .status_o   (q_status)
  );

  p2u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_entry_i   (rd_entry),
    .q_empty_i   (q_status.empty),
    .q_rd_o      (q_rd),
    .pop_i       (pop),
    .empty_o     (empty),
    .utf8_byte_o (utf8_byte_o),
    .item_last_o (item_last_o),
    .text_last_o (text_last_o)
  );

endmodule

`default_nettype wire
